FILE: src/ncs_pkg.sv
// ----------------------------------------------------------------------------
// ncs_pkg
// Shared constants, codes and controller/datapath interface types for the
// nearest centroid search block.
// ----------------------------------------------------------------------------
package ncs_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int ADDR_BITS   = $clog2(MAX_ENTRIES);
    localparam int CNT_BITS    = ADDR_BITS + 1;
    localparam int COORD_BITS  = 16;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int SQ_BITS     = 2 * COORD_BITS;
    localparam int DIST_BITS   = 34;
    localparam int ID_BITS     = 16;
    localparam int SUB_BITS    = 4;
    localparam int MASK_BITS   = 16;
    localparam int SUBDOMAINS  = 16;
    localparam int SUB_LIMIT_I = (SUBDOMAINS < MASK_BITS) ? SUBDOMAINS : MASK_BITS;
    localparam int ACTION_BITS = 2;
    localparam int STATUS_BITS = 3;

    localparam logic [SUB_BITS:0]    SUB_LIMIT = (SUB_BITS + 1)'(SUB_LIMIT_I);
    localparam logic [CNT_BITS-1:0]  CNT_FULL  = CNT_BITS'(MAX_ENTRIES);

    // Input actions
    localparam logic [ACTION_BITS-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_LOAD  = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_QUERY = 2'd2;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] ST_LOADED    = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_CLEARED   = 3'd4;

    typedef enum logic [1:0] {
        OUT_CLEAR = 2'd0,
        OUT_LOAD  = 2'd1,
        OUT_QUERY = 2'd2
    } out_sel_t;

    typedef struct packed {
        logic     do_clear;
        logic     do_load;
        logic     scan_init;
        logic     issue;
        logic     out_write;
        out_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        logic scan_end;
        logic pipe_empty;
        logic out_free;
    } sts_t;

endpackage

FILE: src/nearest_centroid_search_top.sv
// ----------------------------------------------------------------------------
// nearest_centroid_search_top
// Nearest centroid search over a table of up to 1024 3-D Q8.8 points.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one item per transfer: a clear,
//   a load of one table entry, or a query. Output channel (out_valid/
//   out_ready) returns exactly one result per item, in order.
//   Clear and load complete without a table scan; the result is registered
//   and shows in the cycle after the input transfer.
//   A query reads one stored entry per cycle from the table memory read
//   port, runs it through the distance pipeline and posts the result once
//   the pipeline has drained. The memory read port sets that rate.
//   Items are handled one at a time: in_ready is low during a query and
//   while a result waits for the receiver, so with the receiver ready a
//   clear or load can follow every cycle.
//   A stalled receiver holds the result and, with it, the input.
//   Reset empties the table (entry count zero) and clears out_valid; the
//   table contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module nearest_centroid_search_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic        [ncs_pkg::ACTION_BITS-1:0] action,
    input  logic signed [ncs_pkg::COORD_BITS-1:0]  coord_x,
    input  logic signed [ncs_pkg::COORD_BITS-1:0]  coord_y,
    input  logic signed [ncs_pkg::COORD_BITS-1:0]  coord_z,
    input  logic        [ncs_pkg::ID_BITS-1:0]     element_id,
    input  logic        [ncs_pkg::SUB_BITS-1:0]    subdomain,
    input  logic                                   filter_on,
    input  logic        [ncs_pkg::MASK_BITS-1:0]   allowed_mask,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic        [ncs_pkg::STATUS_BITS-1:0] status,
    output logic        [ncs_pkg::ID_BITS-1:0]     found_id,
    output logic        [ncs_pkg::DIST_BITS-1:0]   distance_sq
);

    ncs_pkg::cmd_t cmd;
    ncs_pkg::sts_t sts;

    ncs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .sts      (sts),
        .cmd      (cmd)
    );

    ncs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .element_id   (element_id),
        .subdomain    (subdomain),
        .filter_on    (filter_on),
        .allowed_mask (allowed_mask),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .found_id     (found_id),
        .distance_sq  (distance_sq)
    );

endmodule

FILE: src/ncs_ctrl.sv
// ----------------------------------------------------------------------------
// ncs_ctrl
// Item sequencer: takes input transfers, drives loads and clears directly,
// runs the table scan for a query and posts its result when the pipe drains.
// ----------------------------------------------------------------------------
module ncs_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ncs_pkg::ACTION_BITS-1:0] action,
    input  ncs_pkg::sts_t                   sts,
    output ncs_pkg::cmd_t                   cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE) && sts.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.out_sel   = ncs_pkg::OUT_CLEAR;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        ncs_pkg::ACT_CLEAR:
                        begin
                            cmd.do_clear  = 1'b1;
                            cmd.out_write = 1'b1;
                            cmd.out_sel   = ncs_pkg::OUT_CLEAR;
                        end
                        ncs_pkg::ACT_LOAD:
                        begin
                            cmd.do_load   = 1'b1;
                            cmd.out_write = 1'b1;
                            cmd.out_sel   = ncs_pkg::OUT_LOAD;
                        end
                        default:
                        begin
                            // query, and the unused code behaves the same
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
                if (sts.scan_end)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // wait for the last distance to pass the compare stage and for a free result register
                if (sts.pipe_empty && sts.out_free)
                begin
                    cmd.out_write = 1'b1;
                    cmd.out_sel   = ncs_pkg::OUT_QUERY;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/ncs_datapath.sv
// ----------------------------------------------------------------------------
// ncs_datapath
// Entry table memories, entry count, five-stage distance pipeline with
// running minimum, and the result register.
// ----------------------------------------------------------------------------
module ncs_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ncs_pkg::cmd_t                          cmd,
    output ncs_pkg::sts_t                          sts,
    input  logic signed [ncs_pkg::COORD_BITS-1:0]  coord_x,
    input  logic signed [ncs_pkg::COORD_BITS-1:0]  coord_y,
    input  logic signed [ncs_pkg::COORD_BITS-1:0]  coord_z,
    input  logic        [ncs_pkg::ID_BITS-1:0]     element_id,
    input  logic        [ncs_pkg::SUB_BITS-1:0]    subdomain,
    input  logic                                   filter_on,
    input  logic        [ncs_pkg::MASK_BITS-1:0]   allowed_mask,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic        [ncs_pkg::STATUS_BITS-1:0] status,
    output logic        [ncs_pkg::ID_BITS-1:0]     found_id,
    output logic        [ncs_pkg::DIST_BITS-1:0]   distance_sq
);

    localparam int CW = ncs_pkg::COORD_BITS;
    localparam int TW = ncs_pkg::ID_BITS + ncs_pkg::SUB_BITS;

    logic [3*CW-1:0] cent_mem [ncs_pkg::MAX_ENTRIES];
    logic [TW-1:0]   tag_mem  [ncs_pkg::MAX_ENTRIES];

    logic [ncs_pkg::CNT_BITS-1:0]  count_reg;
    logic [ncs_pkg::CNT_BITS-1:0]  rd_addr_reg;

    // query operands
    logic signed [CW-1:0]           pt_x_reg, pt_y_reg, pt_z_reg;
    logic                           filt_reg;
    logic [ncs_pkg::MASK_BITS-1:0]  mask_reg;

    // stage 1: memory read
    logic                           v1_reg;
    logic [3*CW-1:0]                cent_rd_reg;
    logic [TW-1:0]                  tag_rd_reg;
    // stage 2: differences
    logic                           v2_reg;
    logic signed [ncs_pkg::DIFF_BITS-1:0] dx_reg, dy_reg, dz_reg;
    logic [ncs_pkg::ID_BITS-1:0]    id2_reg;
    // stage 3: squares
    logic                           v3_reg;
    logic [ncs_pkg::SQ_BITS-1:0]    sqx_reg, sqy_reg, sqz_reg;
    logic [ncs_pkg::ID_BITS-1:0]    id3_reg;
    // stage 4: sum
    logic                           v4_reg;
    logic [ncs_pkg::DIST_BITS-1:0]  sum_reg;
    logic [ncs_pkg::ID_BITS-1:0]    id4_reg;
    // running best
    logic                           have_reg;
    logic [ncs_pkg::DIST_BITS-1:0]  best_reg;
    logic [ncs_pkg::ID_BITS-1:0]    best_id_reg;

    logic                           out_valid_reg;
    logic [ncs_pkg::STATUS_BITS-1:0] status_reg;
    logic [ncs_pkg::ID_BITS-1:0]    found_id_reg;
    logic [ncs_pkg::DIST_BITS-1:0]  distance_sq_reg;

    logic                           full;
    logic                           scan_end;
    logic                           issue;
    logic                           wr_en;
    logic                           allowed;
    logic [ncs_pkg::SUB_BITS-1:0]   rd_sub;
    logic signed [CW-1:0]           rd_x, rd_y, rd_z;
    logic signed [2*ncs_pkg::DIFF_BITS-1:0] px, py, pz;
    logic [ncs_pkg::DIST_BITS-1:0]  sum_next;
    logic                           better;

    assign full     = (count_reg == ncs_pkg::CNT_FULL);
    assign scan_end = (rd_addr_reg >= count_reg);
    assign issue    = cmd.issue && !scan_end;
    assign wr_en    = cmd.do_load && !full;

    assign sts.scan_end   = scan_end;
    assign sts.pipe_empty = !(v1_reg || v2_reg || v3_reg || v4_reg);
    assign sts.out_free   = !out_valid_reg || out_ready;

    // table memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cent_mem[count_reg[ncs_pkg::ADDR_BITS-1:0]] <= {coord_x, coord_y, coord_z};
            tag_mem[count_reg[ncs_pkg::ADDR_BITS-1:0]]  <= {element_id, subdomain};
        end
        if (issue)
        begin
            cent_rd_reg <= cent_mem[rd_addr_reg[ncs_pkg::ADDR_BITS-1:0]];
            tag_rd_reg  <= tag_mem[rd_addr_reg[ncs_pkg::ADDR_BITS-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            rd_addr_reg <= '0;
        end
        else
        begin
            if (cmd.do_clear)
            begin
                count_reg <= '0;
            end
            else if (wr_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.scan_init)
            begin
                rd_addr_reg <= '0;
            end
            else if (issue)
            begin
                rd_addr_reg <= rd_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            pt_x_reg <= coord_x;
            pt_y_reg <= coord_y;
            pt_z_reg <= coord_z;
            filt_reg <= filter_on;
            mask_reg <= allowed_mask;
        end
    end

    // stage 2 logic: subdomain filter and coordinate differences
    assign rd_sub  = tag_rd_reg[ncs_pkg::SUB_BITS-1:0];
    assign rd_x    = cent_rd_reg[3*CW-1:2*CW];
    assign rd_y    = cent_rd_reg[2*CW-1:CW];
    assign rd_z    = cent_rd_reg[CW-1:0];
    assign allowed = !filt_reg || (({1'b0, rd_sub} < ncs_pkg::SUB_LIMIT) && mask_reg[rd_sub]);

    // stage 3 logic: squares (magnitudes fit the low SQ_BITS)
    assign px = dx_reg * dx_reg;
    assign py = dy_reg * dy_reg;
    assign pz = dz_reg * dz_reg;

    // stage 4 logic: sum of squares
    assign sum_next = ncs_pkg::DIST_BITS'(sqx_reg) + ncs_pkg::DIST_BITS'(sqy_reg)
                    + ncs_pkg::DIST_BITS'(sqz_reg);

    // strict compare keeps the earliest entry on a tie
    assign better = v4_reg && (!have_reg || (sum_reg < best_reg));

    always_ff @(posedge clk)
    begin
        dx_reg  <= ncs_pkg::DIFF_BITS'(rd_x) - ncs_pkg::DIFF_BITS'(pt_x_reg);
        dy_reg  <= ncs_pkg::DIFF_BITS'(rd_y) - ncs_pkg::DIFF_BITS'(pt_y_reg);
        dz_reg  <= ncs_pkg::DIFF_BITS'(rd_z) - ncs_pkg::DIFF_BITS'(pt_z_reg);
        id2_reg <= tag_rd_reg[TW-1:ncs_pkg::SUB_BITS];
        sqx_reg <= px[ncs_pkg::SQ_BITS-1:0];
        sqy_reg <= py[ncs_pkg::SQ_BITS-1:0];
        sqz_reg <= pz[ncs_pkg::SQ_BITS-1:0];
        id3_reg <= id2_reg;
        sum_reg <= sum_next;
        id4_reg <= id3_reg;
        if (better)
        begin
            best_reg    <= sum_reg;
            best_id_reg <= id4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            have_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg && allowed;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (cmd.scan_init)
            begin
                have_reg <= 1'b0;
            end
            else if (better)
            begin
                have_reg <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_write)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_write)
        begin
            unique case (cmd.out_sel)
                ncs_pkg::OUT_CLEAR:
                begin
                    status_reg      <= ncs_pkg::ST_CLEARED;
                    found_id_reg    <= '0;
                    distance_sq_reg <= '0;
                end
                ncs_pkg::OUT_LOAD:
                begin
                    status_reg      <= full ? ncs_pkg::ST_FULL : ncs_pkg::ST_LOADED;
                    found_id_reg    <= '0;
                    distance_sq_reg <= '0;
                end
                ncs_pkg::OUT_QUERY:
                begin
                    if (have_reg)
                    begin
                        status_reg      <= ncs_pkg::ST_FOUND;
                        found_id_reg    <= best_id_reg;
                        distance_sq_reg <= best_reg;
                    end
                    else
                    begin
                        status_reg      <= ncs_pkg::ST_NOT_FOUND;
                        found_id_reg    <= '0;
                        distance_sq_reg <= '0;
                    end
                end
                default:
                begin
                    status_reg      <= ncs_pkg::ST_CLEARED;
                    found_id_reg    <= '0;
                    distance_sq_reg <= '0;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_id    = found_id_reg;
    assign distance_sq = distance_sq_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ncs_pkg::CNT_FULL)
        else $error("entry count beyond table depth");

    a_scan_init: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_init |=> (!have_reg && rd_addr_reg == '0))
        else $error("scan did not restart from empty best");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_write |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before transfer");

    a_addr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (rd_addr_reg <= count_reg))
        else $error("scan address ran past entry count");

    a_load_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> sts.pipe_empty)
        else $error("table written while a scan is in flight");

endmodule

FILE: tb/nearest_centroid_search_top_tb.sv
// ----------------------------------------------------------------------------
// nearest_centroid_search_top_tb
// Self-checking bench for the nearest centroid search block.
// ----------------------------------------------------------------------------
// A checker class mirrors the entry table and predicts each result: the
// first stored entry with the smallest squared distance that passes the
// subdomain filter. Items run first through a directed list:
//   - empty tables and the query alias of action three
//   - extreme coordinates and the largest distance
//   - ties and duplicate points
//   - masks that reject every entry
//   - clears
// A random mix follows, on tables of mostly small size, and a final clear
// and query close the run. The sender works in bursts with gaps, and the
// receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module nearest_centroid_search_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Upper action code; the block decodes it as a query
    localparam logic [ncs_pkg::ACTION_BITS-1:0] ACT_QUERY_ALT = 2'd3;

    localparam logic signed [ncs_pkg::COORD_BITS-1:0] C_MIN = 16'sh8000;
    localparam logic signed [ncs_pkg::COORD_BITS-1:0] C_MAX = 16'sh7FFF;
    localparam logic signed [ncs_pkg::COORD_BITS-1:0] Q_ONE = 16'sh0100;

    localparam int RANDOM_ITEMS = 556;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct packed {
        logic [ncs_pkg::STATUS_BITS-1:0] status;
        logic [ncs_pkg::ID_BITS-1:0]     id;
        logic [ncs_pkg::DIST_BITS-1:0]   dist_sq;
    } search_result_t;

    typedef struct packed {
        logic [ncs_pkg::COORD_BITS-1:0] x;
        logic [ncs_pkg::COORD_BITS-1:0] y;
        logic [ncs_pkg::COORD_BITS-1:0] z;
    } point_t;

    class centroid_search_checker;
        logic signed [ncs_pkg::COORD_BITS-1:0] pt_x [ncs_pkg::MAX_ENTRIES];
        logic signed [ncs_pkg::COORD_BITS-1:0] pt_y [ncs_pkg::MAX_ENTRIES];
        logic signed [ncs_pkg::COORD_BITS-1:0] pt_z [ncs_pkg::MAX_ENTRIES];
        logic [ncs_pkg::ID_BITS-1:0]           tag_id [ncs_pkg::MAX_ENTRIES];
        logic [ncs_pkg::SUB_BITS-1:0]          tag_sub [ncs_pkg::MAX_ENTRIES];
        int                                    entry_total;
        search_result_t                        pending_answers [$];
        int                                    errors;
        int                                    n_clear;
        int                                    n_load;
        int                                    n_drop;
        int                                    n_query;
        int                                    n_found;

        function new();
            entry_total = 0;
            errors      = 0;
            n_clear     = 0;
            n_load      = 0;
            n_drop      = 0;
            n_query     = 0;
            n_found     = 0;
        endfunction

        function void predict_item(input logic [ncs_pkg::ACTION_BITS-1:0] act,
                                   input logic signed [ncs_pkg::COORD_BITS-1:0] x,
                                   input logic signed [ncs_pkg::COORD_BITS-1:0] y,
                                   input logic signed [ncs_pkg::COORD_BITS-1:0] z,
                                   input logic [ncs_pkg::ID_BITS-1:0] id,
                                   input logic [ncs_pkg::SUB_BITS-1:0] sub,
                                   input logic filt,
                                   input logic [ncs_pkg::MASK_BITS-1:0] mask);
            search_result_t res;
            longint         dx;
            longint         dy;
            longint         dz;
            longint         d;
            longint         best;
            bit             have;
            bit             pass;
            res  = '0;
            have = 1'b0;
            best = 0;
            if (act == ncs_pkg::ACT_CLEAR)
            begin
                entry_total = 0;
                res.status  = ncs_pkg::ST_CLEARED;
                n_clear++;
            end
            else if (act == ncs_pkg::ACT_LOAD)
            begin
                if (entry_total >= ncs_pkg::MAX_ENTRIES)
                begin
                    res.status = ncs_pkg::ST_FULL;
                    n_drop++;
                end
                else
                begin
                    pt_x[entry_total]    = x;
                    pt_y[entry_total]    = y;
                    pt_z[entry_total]    = z;
                    tag_id[entry_total]  = id;
                    tag_sub[entry_total] = sub;
                    entry_total++;
                    res.status = ncs_pkg::ST_LOADED;
                end
                n_load++;
            end
            else
            begin
                for (int n = 0; n < entry_total; n++)
                begin
                    pass = int'(tag_sub[n]) < ncs_pkg::SUBDOMAINS
                        && int'(tag_sub[n]) < ncs_pkg::MASK_BITS
                        && mask[tag_sub[n]];
                    if (filt && !pass)
                        continue;
                    dx = longint'(pt_x[n]) - longint'(x);
                    dy = longint'(pt_y[n]) - longint'(y);
                    dz = longint'(pt_z[n]) - longint'(z);
                    d  = dx * dx + dy * dy + dz * dz;
                    // strict compare: the earliest entry keeps a tie
                    if (!have || d < best)
                    begin
                        have   = 1'b1;
                        best   = d;
                        res.id = tag_id[n];
                    end
                end
                if (have)
                begin
                    res.status  = ncs_pkg::ST_FOUND;
                    res.dist_sq = ncs_pkg::DIST_BITS'(best);
                    n_found++;
                end
                else
                begin
                    res.status = ncs_pkg::ST_NOT_FOUND;
                end
                n_query++;
            end
            pending_answers.insert(pending_answers.size(), res);
        endfunction

        function void check_result(input logic [ncs_pkg::STATUS_BITS-1:0] st,
                                   input logic [ncs_pkg::ID_BITS-1:0] fid,
                                   input logic [ncs_pkg::DIST_BITS-1:0] got_dist);
            search_result_t want;
            if (pending_answers.size() == 0)
            begin
                $error("unexpected result: status %0d found_id %0d distance_sq %0d",
                       st, fid, got_dist);
                errors++;
                return;
            end
            want = pending_answers.pop_front();
            if (st !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, st);
                errors++;
            end
            if (fid !== want.id)
            begin
                $error("found_id: expected %0d, actual %0d", want.id, fid);
                errors++;
            end
            if (got_dist !== want.dist_sq)
            begin
                $error("distance_sq: expected %0d, actual %0d", want.dist_sq, got_dist);
                errors++;
            end
        endfunction
    endclass

    logic                                  clk          = 1'b0;
    logic                                  rst_n        = 1'b0;
    logic                                  in_valid     = 1'b0;
    logic                                  in_ready;
    logic [ncs_pkg::ACTION_BITS-1:0]       action       = ncs_pkg::ACT_CLEAR;
    logic signed [ncs_pkg::COORD_BITS-1:0] coord_x      = '0;
    logic signed [ncs_pkg::COORD_BITS-1:0] coord_y      = '0;
    logic signed [ncs_pkg::COORD_BITS-1:0] coord_z      = '0;
    logic [ncs_pkg::ID_BITS-1:0]           element_id   = '0;
    logic [ncs_pkg::SUB_BITS-1:0]          subdomain    = '0;
    logic                                  filter_on    = 1'b0;
    logic [ncs_pkg::MASK_BITS-1:0]         allowed_mask = '0;
    logic                                  out_valid;
    logic                                  out_ready    = 1'b0;
    logic [ncs_pkg::STATUS_BITS-1:0]       status;
    logic [ncs_pkg::ID_BITS-1:0]           found_id;
    logic [ncs_pkg::DIST_BITS-1:0]         distance_sq;

    centroid_search_checker sb = new();

    int unsigned cycle_count = 0;
    int          burst_left  = 0;
    int          ready_mode  = 0;
    int          mode_left   = 0;
    int          ready_phase = 0;
    int          fill_target = 8;
    point_t      recent_pts [$];

    nearest_centroid_search_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .element_id   (element_id),
        .subdomain    (subdomain),
        .filter_on    (filter_on),
        .allowed_mask (allowed_mask),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .found_id     (found_id),
        .distance_sq  (distance_sq)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Check each result transfer, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(status, found_id, distance_sq);
        if (mode_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 200);
        end
        mode_left--;
        ready_phase++;
        case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 1) != 0);
            default: out_ready <= ((ready_phase % 8) >= 3);
        endcase
    end

    // Present one item, hold it until transfer, then maybe open a gap
    task automatic transfer_item(input logic [ncs_pkg::ACTION_BITS-1:0] act,
                                 input logic signed [ncs_pkg::COORD_BITS-1:0] x,
                                 input logic signed [ncs_pkg::COORD_BITS-1:0] y,
                                 input logic signed [ncs_pkg::COORD_BITS-1:0] z,
                                 input logic [ncs_pkg::ID_BITS-1:0] id,
                                 input logic [ncs_pkg::SUB_BITS-1:0] sub,
                                 input logic filt,
                                 input logic [ncs_pkg::MASK_BITS-1:0] mask);
        action       <= act;
        coord_x      <= x;
        coord_y      <= y;
        coord_z      <= z;
        element_id   <= id;
        subdomain    <= sub;
        filter_on    <= filt;
        allowed_mask <= mask;
        in_valid     <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.predict_item(act, x, y, z, id, sub, filt, mask);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
    endtask

    function automatic logic signed [ncs_pkg::COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return C_MIN;
            1: return C_MAX;
            2, 3, 4, 5: return ncs_pkg::COORD_BITS'($urandom_range(0, 1023) - 512);
            default: return ncs_pkg::COORD_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [ncs_pkg::MASK_BITS-1:0] rand_mask();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return ncs_pkg::MASK_BITS'(1) << $urandom_range(0, ncs_pkg::MASK_BITS - 1);
            default: return ncs_pkg::MASK_BITS'($urandom);
        endcase
    endfunction

    // Random item; loads sometimes repeat a recent point, queries sometimes hit one
    task automatic random_transfer(input logic [ncs_pkg::ACTION_BITS-1:0] act);
        logic signed [ncs_pkg::COORD_BITS-1:0] x;
        logic signed [ncs_pkg::COORD_BITS-1:0] y;
        logic signed [ncs_pkg::COORD_BITS-1:0] z;
        point_t                                pt;
        x = rand_coord();
        y = rand_coord();
        z = rand_coord();
        if (recent_pts.size() > 0 && $urandom_range(0, 5) == 0)
        begin
            pt = recent_pts[$urandom_range(0, recent_pts.size() - 1)];
            x  = pt.x;
            y  = pt.y;
            z  = pt.z;
        end
        if (act == ncs_pkg::ACT_LOAD)
        begin
            pt = {x, y, z};
            recent_pts.insert(recent_pts.size(), pt);
            if (recent_pts.size() > 32)
                void'(recent_pts.pop_front());
        end
        transfer_item(act, x, y, z, ncs_pkg::ID_BITS'($urandom),
                      ncs_pkg::SUB_BITS'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)), rand_mask());
    endtask

    initial
    begin
        int r;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed list
        transfer_item(ncs_pkg::ACT_QUERY, '0, '0, '0, '1, '1, 1'b1, '1);
        transfer_item(ACT_QUERY_ALT, '0, '0, '0, '0, '0, 1'b0, '0);
        transfer_item(ncs_pkg::ACT_LOAD, C_MIN, C_MIN, C_MIN, 16'hFFFF, 4'd15, 1'b1, '1);
        transfer_item(ncs_pkg::ACT_LOAD, C_MAX, C_MAX, C_MAX, 16'h0000, 4'd0, 1'b0, '0);
        transfer_item(ncs_pkg::ACT_QUERY, C_MAX, C_MAX, C_MAX, '1, '1, 1'b0, '0);
        transfer_item(ncs_pkg::ACT_QUERY, C_MAX, C_MAX, C_MAX, '0, '0, 1'b1, 16'h8000);
        transfer_item(ncs_pkg::ACT_QUERY, C_MIN, C_MIN, C_MIN, '0, '0, 1'b1, 16'h0001);
        transfer_item(ncs_pkg::ACT_LOAD, '0, '0, '0, 16'h1234, 4'd5, 1'b0, '0);
        transfer_item(ncs_pkg::ACT_LOAD, Q_ONE, '0, '0, 16'hAAAA, 4'd3, 1'b0, '0);
        transfer_item(ncs_pkg::ACT_LOAD, -Q_ONE, '0, '0, 16'h5555, 4'd3, 1'b0, '0);
        transfer_item(ncs_pkg::ACT_QUERY, '0, '0, '0, '0, '0, 1'b1, 16'h0008);
        transfer_item(ncs_pkg::ACT_QUERY, '0, '0, '0, '0, '0, 1'b1, 16'h0000);
        transfer_item(ncs_pkg::ACT_QUERY, '0, '0, '0, '0, '0, 1'b0, 16'h0000);
        transfer_item(ACT_QUERY_ALT, '0, '0, -Q_ONE, '0, '0, 1'b0, '0);
        transfer_item(ncs_pkg::ACT_LOAD, '0, '0, '0, 16'hBEEF, 4'd6, 1'b0, '0);
        transfer_item(ncs_pkg::ACT_QUERY, '0, '0, '0, '0, '0, 1'b0, '1);
        transfer_item(ncs_pkg::ACT_QUERY, '0, '0, '0, '0, '0, 1'b1, 16'h0040);
        transfer_item(ncs_pkg::ACT_CLEAR, C_MAX, C_MIN, C_MAX, '1, '1, 1'b1, '1);
        transfer_item(ncs_pkg::ACT_QUERY, '0, '0, '0, '0, '0, 1'b0, '0);
        transfer_item(ncs_pkg::ACT_LOAD, 16'sd1, 16'sd1, 16'sd1, 16'd7, 4'd9, 1'b0, '0);
        transfer_item(ncs_pkg::ACT_QUERY, '0, '0, '0, '0, '0, 1'b0, '0);
        transfer_item(ncs_pkg::ACT_CLEAR, '0, '0, '0, '0, '0, 1'b0, '0);

        // Random mix; keep the table mostly small, often clearing once it reaches its target
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3 || (sb.entry_total >= fill_target && r < 25))
            begin
                random_transfer(ncs_pkg::ACT_CLEAR);
                fill_target = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                          : $urandom_range(1, 40);
            end
            else if (r < 55 && sb.entry_total < fill_target)
                random_transfer(ncs_pkg::ACT_LOAD);
            else if (r < 60)
                random_transfer(ACT_QUERY_ALT);
            else
                random_transfer(ncs_pkg::ACT_QUERY);
        end

        random_transfer(ncs_pkg::ACT_CLEAR);
        random_transfer(ncs_pkg::ACT_QUERY);
        in_valid <= 1'b0;

        while (sb.pending_answers.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("run covered %0d clears, %0d loads (%0d dropped on a full table)",
                 sb.n_clear, sb.n_load, sb.n_drop);
        $display("and %0d queries (%0d with a match) in %0d cycles",
                 sb.n_query, sb.n_found, cycle_count);
        if (sb.errors == 0 && sb.pending_answers.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: nearest_centroid_search_top.f
src/ncs_pkg.sv
src/ncs_ctrl.sv
src/ncs_datapath.sv
src/nearest_centroid_search_top.sv
tb/nearest_centroid_search_top_tb.sv
